FILE: design/mdet_pkg.sv
// ============================================================================
// mdet_pkg - shared types and constants for the 4x4 determinant block
// Lane pairing tables for the Laplace expansion and lane control type.
// ============================================================================
package mdet_pkg;

    localparam int DET_WIDTH = 58;
    localparam int NUM_COLS  = 4;
    localparam int NUM_LANES = 6;

    // Column pair of each lane for the rows 0-1 minor, the complementary pair
    // for the rows 2-3 minor, and whether the lane's term is subtracted.
    localparam logic [1:0] AB_I [NUM_LANES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] AB_J [NUM_LANES] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
    localparam logic [1:0] CD_I [NUM_LANES] = '{2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [1:0] CD_J [NUM_LANES] = '{2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1};
    localparam logic       NEG  [NUM_LANES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    // Row indexes within one matrix
    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_THIRD  = 2'd2;
    localparam logic [1:0] ROW_LAST   = 2'd3;

    typedef struct packed {
        logic load_ab;   // capture rows 0-1 minor
        logic load_cd;   // capture rows 2-3 minor
        logic mult_en;   // form the signed product
    } lane_ctrl_t;

endpackage

FILE: design/mdet_lane.sv
// ============================================================================
// mdet_lane - one Laplace term
// Shared 2x2 minor unit, minor registers and the signed minor product.
// ============================================================================
module mdet_lane
    import mdet_pkg::*;
#(
    parameter int  ENTRY_WIDTH = 14,
    parameter int  SUM_W       = 4 * ENTRY_WIDTH + 6,
    parameter logic NEGATE     = 1'b0
) (
    input  logic                          aclk,
    input  lane_ctrl_t                    ctrl,
    input  logic signed [ENTRY_WIDTH-1:0] p_i,
    input  logic signed [ENTRY_WIDTH-1:0] p_j,
    input  logic signed [ENTRY_WIDTH-1:0] q_i,
    input  logic signed [ENTRY_WIDTH-1:0] q_j,
    output logic signed [SUM_W-1:0]       product
);

    localparam int CROSS_W = 2 * ENTRY_WIDTH;
    localparam int MINOR_W = 2 * ENTRY_WIDTH + 1;
    localparam int PROD_W  = 2 * MINOR_W;

    logic signed [CROSS_W-1:0]       cross_a;
    logic signed [CROSS_W-1:0]       cross_b;
    logic signed [MINOR_W-1:0]       minor;
    logic signed [MINOR_W-1:0]       minor_ab_reg;
    logic signed [MINOR_W-1:0]       minor_cd_reg;
    logic signed [PROD_W-1:0]        prod_raw;
    logic signed [SUM_W-1:0]         prod_ext;
    logic signed [SUM_W-1:0]         product_reg;

    assign cross_a = CROSS_W'(p_i) * CROSS_W'(q_j);
    assign cross_b = CROSS_W'(p_j) * CROSS_W'(q_i);
    assign minor   = MINOR_W'(cross_a) - MINOR_W'(cross_b);

    assign prod_raw = PROD_W'(minor_ab_reg) * PROD_W'(minor_cd_reg);
    assign prod_ext = SUM_W'(prod_raw);

    always_ff @(posedge aclk) begin
        if (ctrl.load_ab) begin
            minor_ab_reg <= minor;
        end
        if (ctrl.load_cd) begin
            minor_cd_reg <= minor;
        end
        if (ctrl.mult_en) begin
            product_reg <= NEGATE ? -prod_ext : prod_ext;
        end
    end

    assign product = product_reg;

endmodule

FILE: design/mdet_merge.sv
// ============================================================================
// mdet_merge - lane merge
// Two-level registered adder tree over the six lane products.
// ============================================================================
module mdet_merge
    import mdet_pkg::*;
#(
    parameter int SUM_W = 62
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic signed [SUM_W-1:0] products [NUM_LANES],
    output logic                    out_valid,
    output logic signed [SUM_W-1:0] total,
    output logic                    busy
);

    logic signed [SUM_W-1:0] pair_reg [3];
    logic signed [SUM_W-1:0] total_reg;
    logic                    pair_valid_reg;
    logic                    total_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg  <= 1'b0;
            total_valid_reg <= 1'b0;
        end else begin
            pair_valid_reg  <= in_valid;
            total_valid_reg <= pair_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            for (int k = 0; k < 3; k++) begin
                pair_reg[k] <= products[2*k] + products[2*k+1];
            end
        end
        if (pair_valid_reg) begin
            total_reg <= pair_reg[0] + pair_reg[1] + pair_reg[2];
        end
    end

    assign out_valid = total_valid_reg;
    assign total     = total_reg;
    assign busy      = pair_valid_reg | total_valid_reg;

endmodule

FILE: design/matrix4_determinant_top.sv
// ============================================================================
// matrix4_determinant_top - exact 4x4 determinant, one row per transaction
// Result path: the fourth row passes the lane minor and product registers,
// both merge tree levels and the output register before m_tvalid rises.
// Throughput: rows 0-2 take one cycle each; the fourth row waits until the
// previous matrix has left the lanes, merge tree and output register.
// Reset: synchronous active-low aresetn clears the row counter and all valid
// flags; row and minor registers are not reset.
// ============================================================================
module matrix4_determinant_top
    import mdet_pkg::*;
#(
    parameter int ENTRY_WIDTH = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input rows
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: entry_col0, entry_col1, entry_col2, entry_col3 (lowest first)
    input  logic [((NUM_COLS * ENTRY_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // Result
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: determinant (lowest bits), zero padded
    output logic [((DET_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_DATA_W = ((DET_WIDTH + 7) / 8) * 8;
    localparam int SUM_W      = 4 * ENTRY_WIDTH + 6;

    // ------------------------------------------------------------------
    // Row bookkeeping
    // ------------------------------------------------------------------
    logic [1:0]  row_count_reg;
    logic [1:0]  row_count_next;
    logic signed [ENTRY_WIDTH-1:0] in_row   [NUM_COLS];
    logic signed [ENTRY_WIDTH-1:0] row0_reg [NUM_COLS];
    logic signed [ENTRY_WIDTH-1:0] row2_reg [NUM_COLS];
    logic signed [ENTRY_WIDTH-1:0] p_row    [NUM_COLS];

    logic        accept;
    logic        busy;
    logic        cd_valid_reg;
    logic        prod_valid_reg;
    lane_ctrl_t  lane_ctrl;

    logic signed [SUM_W-1:0] products [NUM_LANES];
    logic                    merge_valid;
    logic signed [SUM_W-1:0] merge_total;
    logic                    merge_busy;

    logic [DET_WIDTH-1:0]    det_value;
    logic [DET_WIDTH-1:0]    det_reg;
    logic                    m_tvalid_reg;

    // Unpack the incoming row; bits above the entries are ignored
    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            in_row[c] = s_tdata[c*ENTRY_WIDTH +: ENTRY_WIDTH];
        end
    end

    // The last row of a matrix needs an empty datapath; earlier rows only
    // touch the row and rows 0-1 minor registers, which are free by then.
    assign busy     = cd_valid_reg | prod_valid_reg | merge_busy | m_tvalid_reg;
    assign s_tready = (row_count_reg != ROW_LAST) | ~busy;
    assign accept   = s_tvalid & s_tready;

    assign row_count_next = accept ? row_count_reg + 2'd1 : row_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= ROW_FIRST;
            cd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            row_count_reg  <= row_count_next;
            cd_valid_reg   <= accept && (row_count_reg == ROW_LAST);
            prod_valid_reg <= cd_valid_reg;
        end
    end

    // Hold row 0 and row 2; row 1 and row 3 feed the lanes directly
    always_ff @(posedge aclk) begin
        if (accept && (row_count_reg == ROW_FIRST)) begin
            row0_reg <= in_row;
        end
        if (accept && (row_count_reg == ROW_THIRD)) begin
            row2_reg <= in_row;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: the minor unit pairs row 0 with row 1, later row 2 with row 3
    // ------------------------------------------------------------------
    always_comb begin
        lane_ctrl.load_ab = accept && (row_count_reg == ROW_SECOND);
        lane_ctrl.load_cd = accept && (row_count_reg == ROW_LAST);
        lane_ctrl.mult_en = cd_valid_reg;
    end

    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            p_row[c] = (row_count_reg == ROW_SECOND) ? row0_reg[c] : row2_reg[c];
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        // The rows 0-1 and rows 2-3 column pairs differ, so select per phase
        logic [1:0] col_i;
        logic [1:0] col_j;

        assign col_i = (row_count_reg == ROW_SECOND) ? AB_I[k] : CD_I[k];
        assign col_j = (row_count_reg == ROW_SECOND) ? AB_J[k] : CD_J[k];

        mdet_lane #(
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .SUM_W       (SUM_W),
            .NEGATE      (NEG[k])
        ) u_lane (
            .aclk    (aclk),
            .ctrl    (lane_ctrl),
            .p_i     (p_row[col_i]),
            .p_j     (p_row[col_j]),
            .q_i     (in_row[col_i]),
            .q_j     (in_row[col_j]),
            .product (products[k])
        );
    end

    // ------------------------------------------------------------------
    // Merge the six signed terms
    // ------------------------------------------------------------------
    mdet_merge #(
        .SUM_W (SUM_W)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid_reg),
        .products  (products),
        .out_valid (merge_valid),
        .total     (merge_total),
        .busy      (merge_busy)
    );

    // Wrap or sign-extend the exact sum to the result width
    if (SUM_W >= DET_WIDTH) begin : g_wrap
        assign det_value = merge_total[DET_WIDTH-1:0];
    end else begin : g_sext
        assign det_value = {{(DET_WIDTH - SUM_W){merge_total[SUM_W-1]}}, merge_total};
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until the transaction completes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (merge_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (merge_valid) begin
            det_reg <= det_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - DET_WIDTH){1'b0}}, det_reg};

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for matrix4_determinant_top
// Streams 4x4 matrices one row per transaction under random sender bursts
// and receiver stalls. A behavioral Laplace expansion predicts each
// determinant, and every result transaction is checked against the oldest
// pending prediction.
// ============================================================================
module tb_top
    import mdet_pkg::*;
();

    localparam int ENTRY_W      = 14;
    localparam int IN_W         = NUM_COLS * ENTRY_W;          // 56, whole bytes
    localparam int OUT_W        = ((DET_WIDTH + 7) / 8) * 8;   // 64
    localparam int RANDOM_MATS  = 150;                         // about 600 rows
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    localparam int ENTRY_MAX = (1 << (ENTRY_W - 1)) - 1;
    localparam int ENTRY_MIN = -(1 << (ENTRY_W - 1));
    localparam int ONE_FIX   = 64;                              // 1.0 with six fraction bits

    // Column 0 sits in the lowest bits, as on s_tdata
    typedef logic [NUM_COLS-1:0][ENTRY_W-1:0] row_t;

    typedef enum int {MIX_FULL, MIX_EXTREME, MIX_SMALL} entry_mix_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata: entry_col0, entry_col1, entry_col2, entry_col3 (lowest first)
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata: determinant (lowest bits), zero padded
    logic [OUT_W-1:0]     m_tdata;

    // Predictor state: rows held so far and index of the next row
    row_t                 held_rows [3];
    logic [1:0]           next_row = ROW_FIRST;
    logic [DET_WIDTH-1:0] pending_dets [$];

    int                   errors    = 0;
    int                   cycle_cnt = 0;
    int                   burst_left = 0;

    matrix4_determinant_top #(
        .ENTRY_WIDTH (ENTRY_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: end the run with a failure once CYCLE_LIMIT is passed
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: m_tready follows a randomly re-picked mode - always ready,
    // coin toss, one cycle in four, rare.
    // ------------------------------------------------------------------------
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_phase = 0;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ((stall_phase % 4) == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [DET_WIDTH-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dets.size() == 0) begin
                $error("determinant transaction with no matrix pending: actual %0d",
                       $signed(m_tdata[DET_WIDTH-1:0]));
                errors++;
            end else begin
                want = pending_dets.pop_front();
                if (m_tdata[DET_WIDTH-1:0] !== want) begin
                    $error("determinant mismatch: expected %0d actual %0d",
                           $signed(want), $signed(m_tdata[DET_WIDTH-1:0]));
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint minor2x2(row_t p, row_t q, int i, int j);
        return longint'($signed(p[i])) * longint'($signed(q[j]))
             - longint'($signed(p[j])) * longint'($signed(q[i]));
    endfunction

    // Laplace expansion along rows 0-1 against complementary minors of rows 2-3
    function automatic longint laplace_det(row_t a, row_t b, row_t c, row_t d);
        return minor2x2(a, b, 0, 1) * minor2x2(c, d, 2, 3)
             - minor2x2(a, b, 0, 2) * minor2x2(c, d, 1, 3)
             + minor2x2(a, b, 0, 3) * minor2x2(c, d, 1, 2)
             + minor2x2(a, b, 1, 2) * minor2x2(c, d, 0, 3)
             - minor2x2(a, b, 1, 3) * minor2x2(c, d, 0, 2)
             + minor2x2(a, b, 2, 3) * minor2x2(c, d, 0, 1);
    endfunction

    // Advance the row index; on the last row queue the expected determinant
    task automatic track_row(row_t r);
        longint det;
        if (next_row == ROW_LAST) begin
            det = laplace_det(held_rows[0], held_rows[1], held_rows[2], r);
            pending_dets.push_back(det[DET_WIDTH-1:0]);
            next_row = ROW_FIRST;
        end else begin
            held_rows[next_row] = r;
            next_row = next_row + 2'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps; junk data while idle
    // ------------------------------------------------------------------------
    task automatic send_row(row_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= IN_W'({$urandom, $urandom});
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do @(posedge aclk); while (!s_tready);
        track_row(r);
    endtask

    task automatic send_matrix(row_t r0, row_t r1, row_t r2, row_t r3);
        send_row(r0);
        send_row(r1);
        send_row(r2);
        send_row(r3);
    endtask

    function automatic row_t make_row(int e0, int e1, int e2, int e3);
        row_t r;
        r[0] = e0[ENTRY_W-1:0];
        r[1] = e1[ENTRY_W-1:0];
        r[2] = e2[ENTRY_W-1:0];
        r[3] = e3[ENTRY_W-1:0];
        return r;
    endfunction

    function automatic int pick_entry(entry_mix_t mix);
        case (mix)
            MIX_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return ENTRY_MIN;
                    1: return ENTRY_MAX;
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            end
            MIX_SMALL: return $urandom_range(0, 255) - 128;
            default:   return $urandom_range(0, (1 << ENTRY_W) - 1) + ENTRY_MIN;
        endcase
    endfunction

    function automatic row_t random_row(entry_mix_t mix);
        return make_row(pick_entry(mix), pick_entry(mix), pick_entry(mix), pick_entry(mix));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Identity gives exactly 1.0 (24 fraction bits in the result); the zero matrix gives zero
    task automatic test_unit_and_zero();
        send_matrix(make_row(ONE_FIX, 0, 0, 0), make_row(0, ONE_FIX, 0, 0),
                    make_row(0, 0, ONE_FIX, 0), make_row(0, 0, 0, ONE_FIX));
        send_matrix(make_row(0, 0, 0, 0), make_row(0, 0, 0, 0),
                    make_row(0, 0, 0, 0), make_row(0, 0, 0, 0));
    endtask

    // Most negative diagonal, a sign pattern of field extremes, all-max rows
    task automatic test_entry_extremes();
        send_matrix(make_row(ENTRY_MIN, 0, 0, 0), make_row(0, ENTRY_MIN, 0, 0),
                    make_row(0, 0, ENTRY_MIN, 0), make_row(0, 0, 0, ENTRY_MIN));
        send_matrix(make_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX),
                    make_row(ENTRY_MAX, ENTRY_MIN, ENTRY_MAX, ENTRY_MIN),
                    make_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MIN, ENTRY_MIN),
                    make_row(ENTRY_MAX, ENTRY_MIN, ENTRY_MIN, ENTRY_MAX));
        send_matrix(make_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX),
                    make_row(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX),
                    make_row(ENTRY_MIN, -1, ENTRY_MIN, -1),
                    make_row(-1, ENTRY_MIN, -1, ENTRY_MIN));
    endtask

    // A repeated row must give zero
    task automatic test_repeated_row();
        row_t r;
        r = random_row(MIX_FULL);
        send_matrix(random_row(MIX_FULL), r, random_row(MIX_FULL), r);
    endtask

    // Random matrices across the row counter wrap, with mixed entry ranges
    task automatic test_random_matrices();
        row_t       rows [4];
        entry_mix_t mix;
        int         pick;
        for (int m = 0; m < RANDOM_MATS; m++) begin
            pick = $urandom_range(0, 9);
            mix  = (pick < 6) ? MIX_FULL : (pick < 8) ? MIX_EXTREME : MIX_SMALL;
            for (int k = 0; k < 4; k++)
                rows[k] = random_row(mix);
            // Sometimes copy an earlier row into the last to force a singular matrix
            if ($urandom_range(0, 6) == 0)
                rows[3] = rows[$urandom_range(0, 2)];
            send_matrix(rows[0], rows[1], rows[2], rows[3]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unit_and_zero();
        test_entry_extremes();
        test_repeated_row();
        test_random_matrices();

        // Drop valid and drain every pending determinant
        s_tvalid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && pending_dets.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: matrix4_determinant_top.f
design/mdet_pkg.sv
design/mdet_lane.sv
design/mdet_merge.sv
design/matrix4_determinant_top.sv
dv/tb_top.sv
